// ===== hdl/atfd_pkg.sv =====
// ============================================================================
// atfd_pkg - instruction format decoder shared definitions
// Class codes, field patterns and types for the format decoder.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package atfd_pkg;

    typedef logic [5:0] class_t;
    typedef logic [4:0] thumb_fmt_t;

    localparam class_t     CLASS_BUBBLE    = 6'd0;
    localparam class_t     THUMB_BASE      = 6'd15;
    localparam class_t     CLASS_UNMATCHED = 6'd35;
    localparam thumb_fmt_t THUMB_NONE      = 5'd0;

    // ARM format codes
    localparam class_t ARM_DATA_PROC  = 6'd1;
    localparam class_t ARM_MUL        = 6'd2;
    localparam class_t ARM_MUL_LONG   = 6'd3;
    localparam class_t ARM_SWAP       = 6'd4;
    localparam class_t ARM_BX         = 6'd5;
    localparam class_t ARM_HALF_REG   = 6'd6;
    localparam class_t ARM_HALF_IMM   = 6'd7;
    localparam class_t ARM_SINGLE_XFR = 6'd8;
    localparam class_t ARM_UNDEF      = 6'd9;
    localparam class_t ARM_BLOCK_XFR  = 6'd10;
    localparam class_t ARM_BRANCH     = 6'd11;
    localparam class_t ARM_CP_XFR     = 6'd12;
    localparam class_t ARM_CP_DATA    = 6'd13;
    localparam class_t ARM_CP_REG     = 6'd14;
    localparam class_t ARM_SWI        = 6'd15;

    // Thumb format numbers, added to THUMB_BASE to form the class
    localparam thumb_fmt_t THUMB_SHIFT     = 5'd1;
    localparam thumb_fmt_t THUMB_ADD_SUB   = 5'd2;
    localparam thumb_fmt_t THUMB_IMM_OP    = 5'd3;
    localparam thumb_fmt_t THUMB_ALU       = 5'd4;
    localparam thumb_fmt_t THUMB_HI_REG    = 5'd5;
    localparam thumb_fmt_t THUMB_PC_LOAD   = 5'd6;
    localparam thumb_fmt_t THUMB_LS_REG    = 5'd7;
    localparam thumb_fmt_t THUMB_LS_SIGN   = 5'd8;
    localparam thumb_fmt_t THUMB_LS_IMM    = 5'd9;
    localparam thumb_fmt_t THUMB_LS_HALF   = 5'd10;
    localparam thumb_fmt_t THUMB_SP_LS     = 5'd11;
    localparam thumb_fmt_t THUMB_LOAD_ADDR = 5'd12;
    localparam thumb_fmt_t THUMB_SP_ADJ    = 5'd13;
    localparam thumb_fmt_t THUMB_PUSH_POP  = 5'd14;
    localparam thumb_fmt_t THUMB_MULTI_LS  = 5'd15;
    localparam thumb_fmt_t THUMB_COND_BR   = 5'd16;
    localparam thumb_fmt_t THUMB_SWI       = 5'd17;
    localparam thumb_fmt_t THUMB_BRANCH    = 5'd18;
    localparam thumb_fmt_t THUMB_LONG_BL   = 5'd19;

    // Branch-exchange pattern over bits 27..4
    localparam logic [23:0] BX_PATTERN = 24'h12FFF1;

endpackage : atfd_pkg

`default_nettype wire

// ===== hdl/atfd_classify.sv =====
// ============================================================================
// atfd_classify - combinational format classifier
// Maps one instruction word, state bit and bubble flag to a format class.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module atfd_classify
    import atfd_pkg::*;
(
    input  wire logic [31:0] instruction_word,
    input  wire logic        thumb_state,
    input  wire logic        bubble,
    output class_t           format_class
);

    class_t     arm_class;
    thumb_fmt_t thumb_fmt;
    logic [15:0] h;

    assign h = instruction_word[15:0];

    // Walk the ARM priority chain
    always_comb
    begin
        priority if (instruction_word[27:26] == 2'b00)
        begin
            priority if (instruction_word[27:22] == 6'b000000 &&
                         instruction_word[7:4] == 4'b1001)
                arm_class = ARM_MUL;
            else if (instruction_word[27:23] == 5'b00001 &&
                     instruction_word[7:4] == 4'b1001)
                arm_class = ARM_MUL_LONG;
            else if (instruction_word[27:23] == 5'b00010 &&
                     instruction_word[21:20] == 2'b00 &&
                     instruction_word[11:4] == 8'b00001001)
                arm_class = ARM_SWAP;
            else if (instruction_word[27:4] == BX_PATTERN)
                arm_class = ARM_BX;
            else if (instruction_word[25] == 1'b0 && instruction_word[22] == 1'b0 &&
                     instruction_word[11:7] == 5'b00001 && instruction_word[4])
                arm_class = ARM_HALF_REG;
            else if (instruction_word[25] == 1'b0 && instruction_word[22] &&
                     instruction_word[7] && instruction_word[4])
                arm_class = ARM_HALF_IMM;
            else
                arm_class = ARM_DATA_PROC;
        end
        else if (instruction_word[27:25] == 3'b011 && instruction_word[4])
            arm_class = ARM_UNDEF;
        else if (instruction_word[27:26] == 2'b01)
            arm_class = ARM_SINGLE_XFR;
        else if (instruction_word[27:25] == 3'b100)
            arm_class = ARM_BLOCK_XFR;
        else if (instruction_word[27:25] == 3'b101)
            arm_class = ARM_BRANCH;
        else if (instruction_word[27:25] == 3'b110)
            arm_class = ARM_CP_XFR;
        else if (instruction_word[27:24] == 4'b1110)
            arm_class = instruction_word[4] ? ARM_CP_REG : ARM_CP_DATA;
        else if (instruction_word[27:24] == 4'b1111)
            arm_class = ARM_SWI;
        else
            arm_class = CLASS_UNMATCHED;
    end

    // Walk the Thumb format chain over the low halfword
    always_comb
    begin
        priority if (h[15:11] == 5'b00011)       thumb_fmt = THUMB_ADD_SUB;
        else if (h[15:13] == 3'b000)             thumb_fmt = THUMB_SHIFT;
        else if (h[15:13] == 3'b001)             thumb_fmt = THUMB_IMM_OP;
        else if (h[15:10] == 6'b010000)          thumb_fmt = THUMB_ALU;
        else if (h[15:10] == 6'b010001)          thumb_fmt = THUMB_HI_REG;
        else if (h[15:11] == 5'b01001)           thumb_fmt = THUMB_PC_LOAD;
        else if (h[15:12] == 4'b0101)
            thumb_fmt = h[9] ? THUMB_LS_SIGN : THUMB_LS_REG;
        else if (h[15:13] == 3'b011)             thumb_fmt = THUMB_LS_IMM;
        else if (h[15:12] == 4'b1000)            thumb_fmt = THUMB_LS_HALF;
        else if (h[15:12] == 4'b1001)            thumb_fmt = THUMB_SP_LS;
        else if (h[15:12] == 4'b1010)            thumb_fmt = THUMB_LOAD_ADDR;
        else if (h[15:12] == 4'b1011)
            thumb_fmt = h[10] ? THUMB_PUSH_POP : THUMB_SP_ADJ;
        else if (h[15:12] == 4'b1100)            thumb_fmt = THUMB_MULTI_LS;
        else if (h[15:12] == 4'b1101)
            thumb_fmt = (h[11:8] == 4'b1111) ? THUMB_SWI : THUMB_COND_BR;
        else if (h[15:12] == 4'b1110)            thumb_fmt = THUMB_BRANCH;
        else if (h[15:12] == 4'b1111)            thumb_fmt = THUMB_LONG_BL;
        else                                     thumb_fmt = THUMB_NONE;
    end

    // Pick bubble, Thumb or ARM result
    always_comb
    begin
        priority if (bubble)
            format_class = CLASS_BUBBLE;
        else if (thumb_state)
            format_class = (thumb_fmt != THUMB_NONE) ?
                           class_t'(THUMB_BASE + {1'b0, thumb_fmt}) : CLASS_UNMATCHED;
        else
            format_class = arm_class;
    end

endmodule : atfd_classify

`default_nettype wire

// ===== hdl/arm_thumb_format_decoder.sv =====
// Flow: a word taken with start is held in the input registers, classified and
// caught in the result register, shown on format_class and marked by done for one cycle.
// Throughput: one word per cycle; busy stays low, since the only work is one
// pass through the classifier between the input and result registers.
// Reset: rst_n clears the valid and done flags; payload registers are not reset.
// ============================================================================
// arm_thumb_format_decoder - instruction format decoder top level
// Registers each fetched word, classifies it and registers the class.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module arm_thumb_format_decoder
    import atfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] instruction_word,
    input  wire logic        thumb_state,
    input  wire logic        bubble,
    output logic             done,
    output logic [5:0]       format_class
);

    logic        valid_reg;
    logic [31:0] word_reg;
    logic        thumb_reg;
    logic        bubble_reg;
    logic        done_reg;
    class_t      class_reg;
    class_t      class_next;
    logic        accept;

    // Take a word whenever start is high; the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Hold the accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg   <= instruction_word;
            thumb_reg  <= thumb_state;
            bubble_reg <= bubble;
        end
    end

    atfd_classify u_classify (
        .instruction_word (word_reg),
        .thumb_state      (thumb_reg),
        .bubble           (bubble_reg),
        .format_class     (class_next)
    );

    // Advance the class into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
            class_reg <= class_next;
    end

    assign done         = done_reg;
    assign format_class = class_reg;

endmodule : arm_thumb_format_decoder

`default_nettype wire

// ===== hdl/atfd_checker.sv =====
// ============================================================================
// atfd_checker - port-level checks for the format decoder
// Watches the top level's ports and is bound to every instance of it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module atfd_checker
    import atfd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        thumb_state,
    input wire logic        bubble,
    input wire logic        done,
    input wire logic [5:0]  format_class
);

    // Each word taken yields its result once it has passed the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("word taken without a result two cycles later");

    // A result needs a word taken earlier that has passed the input and result registers
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching word");

    // A bubble comes out as the bubble class
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && bubble) |=> ##1 (format_class == CLASS_BUBBLE))
        else $error("bubble not passed as bubble class");

    // A real Thumb word lands in the Thumb class range
    a_thumb_range: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !bubble && thumb_state) |=> ##1
        (format_class > THUMB_BASE && format_class < CLASS_UNMATCHED))
        else $error("Thumb word outside the Thumb class range");

    // Every pattern is covered, so nothing comes out unmatched
    a_matched: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (format_class != CLASS_UNMATCHED))
        else $error("unmatched class produced");

endmodule : atfd_checker

bind arm_thumb_format_decoder atfd_checker u_atfd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .thumb_state      (thumb_state),
    .bubble           (bubble),
    .done             (done),
    .format_class     (format_class)
);

`default_nettype wire

// ===== dv/tb_arm_thumb_format_decoder.sv =====
// ============================================================================
// tb_arm_thumb_format_decoder - format decoder testbench
// Drives fetched words in ARM state, Thumb state and as bubbles, predicts
// each format class and checks every done strobe against the oldest
// prediction. Covers directed corner words, shaped random words per state,
// back-to-back issue and a full drain between batches.
// ============================================================================
`timescale 1ns / 1ps

module tb_arm_thumb_format_decoder;

    import atfd_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic        thumb;
        logic        bub;
        class_t      cls;
    } fetch_expect_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] instruction_word = 32'h0;
    logic        thumb_state = 1'b0;
    logic        bubble = 1'b0;
    logic        busy;
    logic        done;
    logic [5:0]  format_class;

    fetch_expect_t pending_classes[$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          classes_checked = 0;
    logic [35:0] classes_seen = '0;
    bit          back_to_back = 1'b0;

    arm_thumb_format_decoder uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .instruction_word (instruction_word),
        .thumb_state      (thumb_state),
        .bubble           (bubble),
        .done             (done),
        .format_class     (format_class)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the decoder hangs
    initial
    begin
        #2_000_000;
        $display("FAIL arm_thumb_format_decoder");
        $finish;
    end

    // Classify an ARM-state word by the priority chain
    function automatic class_t arm_class(input logic [31:0] w);
        if (w[27:26] == 2'b00)
        begin
            if (w[27:22] == 6'b000000 && w[7:4] == 4'h9)
                return ARM_MUL;
            if (w[27:23] == 5'b00001 && w[7:4] == 4'h9)
                return ARM_MUL_LONG;
            if (w[27:23] == 5'b00010 && w[21:20] == 2'b00 && w[11:4] == 8'h09)
                return ARM_SWAP;
            if (w[27:4] == BX_PATTERN)
                return ARM_BX;
            if (w[27:25] == 3'b000 && !w[22] && w[11:7] == 5'b00001 && w[4])
                return ARM_HALF_REG;
            if (w[27:25] == 3'b000 && w[22] && w[7] && w[4])
                return ARM_HALF_IMM;
            return ARM_DATA_PROC;
        end
        if (w[27:25] == 3'b011 && w[4])
            return ARM_UNDEF;
        if (w[27:26] == 2'b01)
            return ARM_SINGLE_XFR;
        if (w[27:25] == 3'b100)
            return ARM_BLOCK_XFR;
        if (w[27:25] == 3'b101)
            return ARM_BRANCH;
        if (w[27:25] == 3'b110)
            return ARM_CP_XFR;
        if (w[27:24] == 4'hE)
            return w[4] ? ARM_CP_REG : ARM_CP_DATA;
        if (w[27:24] == 4'hF)
            return ARM_SWI;
        return CLASS_UNMATCHED;
    endfunction

    // Pick the Thumb format from the low halfword
    function automatic thumb_fmt_t thumb_format(input logic [15:0] h);
        if (h[15:11] == 5'b00011) return THUMB_ADD_SUB;
        if (h[15:13] == 3'b000) return THUMB_SHIFT;
        if (h[15:13] == 3'b001) return THUMB_IMM_OP;
        if (h[15:10] == 6'b010000) return THUMB_ALU;
        if (h[15:10] == 6'b010001) return THUMB_HI_REG;
        if (h[15:11] == 5'b01001) return THUMB_PC_LOAD;
        if (h[15:12] == 4'h5) return h[9] ? THUMB_LS_SIGN : THUMB_LS_REG;
        if (h[15:13] == 3'b011) return THUMB_LS_IMM;
        case (h[15:12])
            4'h8: return THUMB_LS_HALF;
            4'h9: return THUMB_SP_LS;
            4'hA: return THUMB_LOAD_ADDR;
            4'hB: return h[10] ? THUMB_PUSH_POP : THUMB_SP_ADJ;
            4'hC: return THUMB_MULTI_LS;
            4'hD: return (h[11:8] == 4'hF) ? THUMB_SWI : THUMB_COND_BR;
            4'hE: return THUMB_BRANCH;
            4'hF: return THUMB_LONG_BL;
            default: return THUMB_NONE;
        endcase
    endfunction

    function automatic class_t predict_format_class(input logic [31:0] w,
                                                    input logic thumb,
                                                    input logic bub);
        thumb_fmt_t f;
        if (bub)
            return CLASS_BUBBLE;
        if (!thumb)
            return arm_class(w);
        f = thumb_format(w[15:0]);
        return (f == THUMB_NONE) ? CLASS_UNMATCHED : class_t'(THUMB_BASE + f);
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int idle_gap();
        int r;
        if (back_to_back)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // ARM word shaped toward one format, rest of the bits random
    function automatic logic [31:0] arm_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            1: begin w[27:22] = 6'b000000; w[7:4] = 4'h9; end
            2: begin w[27:23] = 5'b00001; w[7:4] = 4'h9; end
            3: begin w[27:23] = 5'b00010; w[21:20] = 2'b00; w[11:4] = 8'h09; end
            4: w[27:4] = BX_PATTERN;
            5: begin w[27:25] = 3'b000; w[22] = 1'b0; w[11:7] = 5'b00001; w[4] = 1'b1; end
            6: begin w[27:25] = 3'b000; w[22] = 1'b1; w[7] = 1'b1; w[4] = 1'b1; end
            7: begin w[27:25] = 3'b011; w[4] = 1'b1; end
            // near misses around the multiply and halfword patterns
            8: begin w[27:26] = 2'b00; w[7] = 1'b1; w[4] = 1'b1; end
            default: ;
        endcase
        return w;
    endfunction

    // Thumb word, with the software-interrupt group boosted
    function automatic logic [31:0] thumb_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 7) == 0)
            w[15:8] = 8'hDF;
        return w;
    endfunction

    // Issue one word, hold it until taken and queue its class
    task automatic send_word(input logic [31:0] w, input logic thumb,
                             input logic bub);
        int gap;
        fetch_expect_t e;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        instruction_word <= w;
        thumb_state      <= thumb;
        bubble           <= bub;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        e.word  = w;
        e.thumb = thumb;
        e.bub   = bub;
        e.cls   = predict_format_class(w, thumb, bub);
        pending_classes.push_back(e);
        words_sent++;
    endtask

    // Drop start and hold until every queued class has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_classes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        // all-zero and all-one words, both states
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        // bubble wins over state and word
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        // one word per ARM format but the software interrupt
        send_word(32'hE1A0_0000, 1'b0, 1'b0);
        send_word(32'hE000_0091, 1'b0, 1'b0);
        send_word(32'hE080_0091, 1'b0, 1'b0);
        send_word(32'hE100_0091, 1'b0, 1'b0);
        send_word(32'hE12F_FF11, 1'b0, 1'b0);
        send_word(32'hE000_00B1, 1'b0, 1'b0);
        send_word(32'hE040_00B1, 1'b0, 1'b0);
        send_word(32'hE600_0010, 1'b0, 1'b0);
        send_word(32'hE590_0000, 1'b0, 1'b0);
        send_word(32'hE8BD_0000, 1'b0, 1'b0);
        send_word(32'hEA00_0000, 1'b0, 1'b0);
        send_word(32'hEC00_0000, 1'b0, 1'b0);
        send_word(32'hEE00_0000, 1'b0, 1'b0);
        send_word(32'hEE00_0010, 1'b0, 1'b0);
        // Thumb add/subtract, SP adjust vs push/pop, SWI vs conditional branch
        send_word(32'h0000_1800, 1'b1, 1'b0);
        send_word(32'h0000_B000, 1'b1, 1'b0);
        send_word(32'h0000_B400, 1'b1, 1'b0);
        send_word(32'h0000_DF00, 1'b1, 1'b0);
        send_word(32'h0000_D0FF, 1'b1, 1'b0);
    endtask

    task automatic test_arm_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(arm_word(), 1'b0, 1'b0);
    endtask

    task automatic test_thumb_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(thumb_word(), 1'b1, 1'b0);
    endtask

    // Interleave states and bubbles as a real fetch stream would
    task automatic test_mixed_random(input int count);
        logic thumb;
        for (int i = 0; i < count; i++)
        begin
            thumb = 1'($urandom_range(0, 1));
            send_word(thumb ? thumb_word() : arm_word(), thumb,
                      $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic test_back_to_back(input int count);
        back_to_back = 1'b1;
        test_mixed_random(count);
        back_to_back = 1'b0;
    endtask

    // Let the decoder run dry between batches
    task automatic test_drain_pause(input int batches);
        for (int b = 0; b < batches; b++)
        begin
            test_mixed_random(20);
            drain_results();
        end
    endtask

    // Compare each done strobe with the oldest queued class
    always @(posedge clk)
    begin : class_checker
        fetch_expect_t e;
        if (rst_n && done === 1'b1)
        begin
            if (pending_classes.size() == 0)
            begin
                $display("%0t: unexpected class %0d with nothing queued",
                         $time, format_class);
                mismatch_count++;
            end
            else
            begin
                e = pending_classes.pop_front();
                classes_checked++;
                if (format_class !== e.cls)
                begin
                    $display("%0t: word %h thumb %b bubble %b expected %0d actual %0d",
                             $time, e.word, e.thumb, e.bub, e.cls, format_class);
                    mismatch_count++;
                end
                else
                    classes_seen[e.cls] = 1'b1;
            end
        end
    end

    initial
    begin
        int wait_cycles;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_arm_random(700);
        test_thumb_random(600);
        test_mixed_random(500);
        test_back_to_back(150);
        test_drain_pause(3);

        // Wait out the pipeline, bounded
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_classes.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (pending_classes.size() != 0)
        begin
            $display("%0t: %0d classes never arrived", $time, pending_classes.size());
            mismatch_count++;
        end
        repeat (4) @(posedge clk);

        $display("Issued %0d words in ARM, Thumb and bubble slots; %0d classes checked",
                 words_sent, classes_checked);
        $display("Distinct format classes decoded correctly: %0d of 35",
                 $countones(classes_seen));
        if (mismatch_count == 0)
            $display("PASS arm_thumb_format_decoder");
        else
            $display("FAIL arm_thumb_format_decoder");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/atfd_pkg.sv
hdl/atfd_classify.sv
hdl/arm_thumb_format_decoder.sv
hdl/atfd_checker.sv
dv/tb_arm_thumb_format_decoder.sv
